FILE: hw/rtl/acm_pkg.sv
// Shared types, constants and helpers of the accumulator machine core.
package acm_pkg;

  // Word memory geometry
  localparam int MEM_WORDS = 100;
  localparam int ADDR_W    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  // Fixed field widths
  localparam int WORD_W = 15;
  localparam int PC_W   = 7;
  localparam int OPC_W  = 8;
  localparam int OPD_W  = 7;
  localparam int MAG_W  = 14;
  localparam int PROD_W = 2 * WORD_W;
  localparam int DIV_CNT_W = $clog2(MAG_W + 1);

  localparam logic signed [WORD_W-1:0] WORD_MAX = 15'sd9999;

  // Divide by one hundred: multiply by reciprocal, then shift
  localparam logic [12:0] RECIP       = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [6:0]  DEC_BASE    = 7'd100;

  // Instruction codes
  localparam logic [OPC_W-1:0] OPC_NOP    = 8'd0;
  localparam logic [OPC_W-1:0] OPC_READ   = 8'd10;
  localparam logic [OPC_W-1:0] OPC_WRITE  = 8'd11;
  localparam logic [OPC_W-1:0] OPC_LOAD   = 8'd20;
  localparam logic [OPC_W-1:0] OPC_STORE  = 8'd21;
  localparam logic [OPC_W-1:0] OPC_ADD    = 8'd30;
  localparam logic [OPC_W-1:0] OPC_SUB    = 8'd31;
  localparam logic [OPC_W-1:0] OPC_DIV    = 8'd32;
  localparam logic [OPC_W-1:0] OPC_MUL    = 8'd33;
  localparam logic [OPC_W-1:0] OPC_BR     = 8'd40;
  localparam logic [OPC_W-1:0] OPC_BRNEG  = 8'd41;
  localparam logic [OPC_W-1:0] OPC_BRZERO = 8'd42;
  localparam logic [OPC_W-1:0] OPC_HALT   = 8'd43;
  localparam logic [OPC_W-1:0] OPC_BAD    = 8'd255;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_LOAD_REJ = 4'd1,
    ST_HALTED   = 4'd2,
    ST_OVERFLOW = 4'd3,
    ST_DIV_ZERO = 4'd4,
    ST_BAD_OPC  = 4'd5,
    ST_OFF_END  = 4'd6,
    ST_STOPPED  = 4'd7,
    ST_BAD_ADDR = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    PH_LOADING = 2'd0,
    PH_RUNNING = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CM_NONE    = 3'd0,
    CM_STOPPED = 3'd1,
    CM_OFF_END = 3'd2,
    CM_LOAD    = 3'd3,
    CM_EXEC    = 3'd4
  } commit_e;

  typedef enum logic [3:0] {
    S_IDLE     = 4'd0,
    S_LOAD_DEC = 4'd1,
    S_LOAD     = 4'd2,
    S_FETCH    = 4'd3,
    S_DECODE   = 4'd4,
    S_OPERAND  = 4'd5,
    S_EXEC     = 4'd6,
    S_MULT     = 4'd7,
    S_DIVIDE   = 4'd8
  } state_e;

  typedef enum logic {
    RD_PC  = 1'b0,
    RD_OPD = 1'b1
  } rd_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    dec_en;
    logic    dec_load;
    logic    mul_en;
    logic    div_start;
    commit_e commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    phase_e phase;
    logic   pc_off;
    logic   is_mul;
    logic   is_div;
    logic   div_done;
  } dp_status_t;

  function automatic logic opcode_known(input logic [OPC_W-1:0] opc);
    logic known;
    case (opc)
      OPC_NOP, OPC_READ, OPC_WRITE, OPC_LOAD, OPC_STORE, OPC_ADD, OPC_SUB,
      OPC_DIV, OPC_MUL, OPC_BR, OPC_BRNEG, OPC_BRZERO, OPC_HALT: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

FILE: hw/rtl/acm_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
module acm_div import acm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] dividend_i,
  input  logic [MAG_W-1:0] divisor_i,
  output logic             done_o,
  output logic [MAG_W-1:0] quotient_o
);

  logic                 active_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [MAG_W-1:0]     rem_q, quo_q, dvs_q;
  logic [MAG_W:0]       trial, diff;
  logic                 ge;

  // Trial subtraction of the shifted remainder
  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (start_i) begin
      active_q <= 1'b1;
      cnt_q    <= DIV_CNT_W'(MAG_W);
    end else if (active_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        active_q <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (active_q) begin
      rem_q <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo_q <= {quo_q[MAG_W-2:0], ge};
    end
  end

  assign done_o     = !active_q;
  assign quotient_o = quo_q;

endmodule

FILE: hw/rtl/acm_datapath.sv
// Datapath: word memory, accumulator, counter, decoder, multiplier, divider.
module acm_datapath import acm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  input  logic [PC_W-1:0]          address_i,
  input  logic signed [WORD_W-1:0] word_i,
  input  logic signed [WORD_W-1:0] read_value_i,
  output dp_status_t               st_o,
  output logic                     done_o,
  output logic [3:0]               status_o,
  output logic                     write_valid_o,
  output logic [OPD_W-1:0]         write_address_o,
  output logic signed [WORD_W-1:0] write_value_o,
  output logic signed [WORD_W-1:0] accumulator_now_o,
  output logic [PC_W-1:0]          counter_now_o
);

  // Architectural state
  logic signed [WORD_W-1:0] acc_q;
  logic [PC_W-1:0]          pc_q;
  phase_e                   phase_q;

  // Result registers
  logic                     done_q;
  status_e                  status_q;
  logic                     wvalid_q;
  logic [OPD_W-1:0]         waddr_q;
  logic signed [WORD_W-1:0] wval_q;

  // Latched item
  logic [PC_W-1:0]          addr_in_q;
  logic signed [WORD_W-1:0] word_in_q, rv_in_q;

  // Memory
  logic [WORD_W-1:0]        mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0]     vld_q;
  logic [WORD_W-1:0]        rd_data_q;
  logic                     rd_vld_q;
  logic [ADDR_W-1:0]        ra, wa;
  logic                     mem_we;
  logic [WORD_W-1:0]        mem_wd;
  logic signed [WORD_W-1:0] rdata;

  // Decoder
  logic signed [WORD_W-1:0] dec_src;
  logic                     dec_neg;
  logic [WORD_W-1:0]        dec_mag, dec_q100, dec_rem;
  logic [27:0]              dec_prod;
  logic [OPC_W-1:0]         dec_quo;
  logic                     dec_neg_q;
  logic [OPC_W-1:0]         dec_quo_q;
  logic [OPD_W-1:0]         dec_rem_q;
  logic [OPC_W-1:0]         opc;
  logic                     op_known, addr_ok;
  logic [ADDR_W-1:0]        opd_idx;

  // Arithmetic
  logic signed [PROD_W-1:0] prod_q;
  logic signed [15:0]       sum, dif;
  logic signed [WORD_W-1:0] rv_sat;
  logic [WORD_W-1:0]        acc_abs, opnd_abs, quo_ext;
  logic [MAG_W-1:0]         quo_mag;
  logic                     div_done, div_neg, load_ok;

  // Execute results
  status_e                  ex_status;
  phase_e                   ex_phase;
  logic                     ex_stop, ex_wvalid, ex_we;
  logic signed [WORD_W-1:0] ex_acc, ex_wd;
  logic [PC_W-1:0]          ex_next, ex_pc;

  function automatic logic [WORD_W-1:0] abs_w(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

  function automatic logic beyond(input logic signed [PROD_W-1:0] v);
    return (v > PROD_W'(WORD_MAX)) || (v < -PROD_W'(WORD_MAX));
  endfunction

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      addr_in_q <= address_i;
      word_in_q <= word_i;
      rv_in_q   <= read_value_i;
    end
  end

  // Memory read port, registered
  assign opd_idx = addr_ok ? dec_rem_q[ADDR_W-1:0] : '0;
  assign ra      = (cmd_i.rd_sel == RD_PC) ? pc_q[ADDR_W-1:0] : opd_idx;
  assign rdata   = rd_vld_q ? $signed(rd_data_q) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[ra];
      rd_vld_q  <= vld_q[ra];
    end
  end

  // Written flags: an unwritten word reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (mem_we) begin
      vld_q[wa] <= 1'b1;
    end
  end

  // Split word into opcode and operand (truncating toward zero)
  assign dec_src  = cmd_i.dec_load ? word_in_q : rdata;
  assign dec_neg  = dec_src[WORD_W-1];
  assign dec_mag  = abs_w(dec_src);
  assign dec_prod = dec_mag * RECIP;
  assign dec_quo  = dec_prod[RECIP_SHIFT +: OPC_W];
  assign dec_q100 = WORD_W'(dec_quo) * WORD_W'(DEC_BASE);
  assign dec_rem  = dec_mag - dec_q100;

  always_ff @(posedge clk_i) begin
    if (cmd_i.dec_en) begin
      dec_neg_q <= dec_neg;
      dec_quo_q <= dec_quo;
      dec_rem_q <= dec_rem[OPD_W-1:0];
    end
  end

  // Negative words: only those with a zero quotient decode as no-op
  always_comb begin
    if (!dec_neg_q) begin
      opc = dec_quo_q;
    end else if (dec_quo_q == '0) begin
      opc = OPC_NOP;
    end else begin
      opc = OPC_BAD;
    end
  end

  assign op_known = opcode_known(opc);
  assign addr_ok  = dec_rem_q < OPD_W'(MEM_WORDS);

  // Multiplier, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= acc_q * rdata;
    end
  end

  // Divider on magnitudes
  assign acc_abs  = abs_w(acc_q);
  assign opnd_abs = abs_w(rdata);
  assign div_neg  = acc_q[WORD_W-1] ^ rdata[WORD_W-1];

  acm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_abs[MAG_W-1:0]),
    .divisor_i  (opnd_abs[MAG_W-1:0]),
    .done_o     (div_done),
    .quotient_o (quo_mag)
  );

  assign quo_ext = {1'b0, quo_mag};

  // Add, subtract, saturated read value
  assign sum = {acc_q[WORD_W-1], acc_q} + {rdata[WORD_W-1], rdata};
  assign dif = {acc_q[WORD_W-1], acc_q} - {rdata[WORD_W-1], rdata};

  always_comb begin
    if (rv_in_q > WORD_MAX) begin
      rv_sat = WORD_MAX;
    end else if (rv_in_q < -WORD_MAX) begin
      rv_sat = -WORD_MAX;
    end else begin
      rv_sat = rv_in_q;
    end
  end

  // Load validation
  assign load_ok = (phase_q == PH_LOADING) && (addr_in_q < PC_W'(MEM_WORDS)) &&
                   !word_in_q[WORD_W-1] && (word_in_q <= WORD_MAX) &&
                   !dec_neg_q && opcode_known(dec_quo_q) && addr_ok;

  // Instruction execution
  always_comb begin
    ex_status = ST_OK;
    ex_stop   = 1'b0;
    ex_acc    = acc_q;
    ex_next   = pc_q + PC_W'(1);
    ex_wvalid = 1'b0;
    ex_we     = 1'b0;
    ex_wd     = acc_q;
    if (!op_known) begin
      ex_status = ST_BAD_OPC;
      ex_stop   = 1'b1;
    end else if ((opc != OPC_NOP) && !addr_ok) begin
      ex_status = ST_BAD_ADDR;
      ex_stop   = 1'b1;
    end else begin
      case (opc)
        OPC_READ: begin
          ex_we = 1'b1;
          ex_wd = rv_sat;
        end
        OPC_WRITE: ex_wvalid = 1'b1;
        OPC_LOAD:  ex_acc = rdata;
        OPC_STORE: ex_we = 1'b1;
        OPC_ADD: begin
          if (beyond(PROD_W'(sum))) begin
            ex_status = ST_OVERFLOW;
            ex_acc    = '0;
            ex_stop   = 1'b1;
          end else begin
            ex_acc = sum[WORD_W-1:0];
          end
        end
        OPC_SUB: begin
          if (beyond(PROD_W'(dif))) begin
            ex_status = ST_OVERFLOW;
            ex_acc    = '0;
            ex_stop   = 1'b1;
          end else begin
            ex_acc = dif[WORD_W-1:0];
          end
        end
        OPC_MUL: begin
          if (beyond(prod_q)) begin
            ex_status = ST_OVERFLOW;
            ex_acc    = '0;
            ex_stop   = 1'b1;
          end else begin
            ex_acc = prod_q[WORD_W-1:0];
          end
        end
        OPC_DIV: begin
          if (rdata == '0) begin
            ex_status = ST_DIV_ZERO;
            ex_acc    = '0;
            ex_stop   = 1'b1;
          end else begin
            ex_acc = div_neg ? $signed(WORD_W'(0) - quo_ext) : $signed(quo_ext);
          end
        end
        OPC_BR:     ex_next = dec_rem_q;
        OPC_BRNEG:  if (acc_q < 0) ex_next = dec_rem_q;
        OPC_BRZERO: if (acc_q == '0) ex_next = dec_rem_q;
        OPC_HALT: begin
          ex_status = ST_HALTED;
          ex_stop   = 1'b1;
        end
        default: ;
      endcase
    end
    // Counter update and running off the end
    ex_phase = PH_RUNNING;
    ex_pc    = pc_q;
    if (ex_stop) begin
      ex_phase = PH_STOPPED;
    end else begin
      ex_pc = ex_next;
      if (ex_next >= PC_W'(MEM_WORDS)) begin
        ex_status = ST_OFF_END;
        ex_phase  = PH_STOPPED;
      end
    end
  end

  // Memory write port selection
  assign mem_we = ((cmd_i.commit == CM_LOAD) && load_ok) || ((cmd_i.commit == CM_EXEC) && ex_we);
  assign wa     = (cmd_i.commit == CM_LOAD) ? addr_in_q[ADDR_W-1:0] : opd_idx;
  assign mem_wd = (cmd_i.commit == CM_LOAD) ? word_in_q : ex_wd;

  // Commit of state and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      pc_q     <= '0;
      phase_q  <= PH_LOADING;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      wvalid_q <= 1'b0;
      waddr_q  <= '0;
      wval_q   <= '0;
    end else begin
      done_q <= cmd_i.commit != CM_NONE;
      case (cmd_i.commit)
        CM_STOPPED: begin
          status_q <= ST_STOPPED;
          wvalid_q <= 1'b0;
          waddr_q  <= '0;
          wval_q   <= '0;
        end
        CM_OFF_END: begin
          status_q <= ST_OFF_END;
          phase_q  <= PH_STOPPED;
          wvalid_q <= 1'b0;
          waddr_q  <= '0;
          wval_q   <= '0;
        end
        CM_LOAD: begin
          status_q <= load_ok ? ST_OK : ST_LOAD_REJ;
          wvalid_q <= 1'b0;
          waddr_q  <= '0;
          wval_q   <= '0;
        end
        CM_EXEC: begin
          status_q <= ex_status;
          phase_q  <= ex_phase;
          acc_q    <= ex_acc;
          pc_q     <= ex_pc;
          wvalid_q <= ex_wvalid;
          waddr_q  <= ex_wvalid ? dec_rem_q : '0;
          wval_q   <= ex_wvalid ? rdata : '0;
        end
        default: ;
      endcase
    end
  end

  // Status to controller
  assign st_o.phase    = phase_q;
  assign st_o.pc_off   = pc_q >= PC_W'(MEM_WORDS);
  assign st_o.is_mul   = op_known && addr_ok && (opc == OPC_MUL);
  assign st_o.is_div   = op_known && addr_ok && (opc == OPC_DIV) && (rdata != '0);
  assign st_o.div_done = div_done;

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign write_valid_o     = wvalid_q;
  assign write_address_o   = waddr_q;
  assign write_value_o     = wval_q;
  assign accumulator_now_o = acc_q;
  assign counter_now_o     = pc_q;

endmodule

FILE: hw/rtl/acm_ctrl.sv
// Controller: sequences load and instruction items through the datapath.
module acm_ctrl import acm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       operation_i,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && (st_i.phase != PH_STOPPED)) begin
          if (!operation_i) begin
            state_d = S_LOAD_DEC;
          end else if (!st_i.pc_off) begin
            state_d = S_FETCH;
          end
        end
      end
      S_LOAD_DEC: state_d = S_LOAD;
      S_LOAD:     state_d = S_IDLE;
      S_FETCH:    state_d = S_DECODE;
      S_DECODE:   state_d = S_OPERAND;
      S_OPERAND:  state_d = S_EXEC;
      S_EXEC: begin
        if (st_i.is_mul) begin
          state_d = S_MULT;
        end else if (st_i.is_div) begin
          state_d = S_DIVIDE;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MULT:   state_d = S_IDLE;
      S_DIVIDE: if (st_i.div_done) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '{latch: 1'b0, rd_en: 1'b0, rd_sel: RD_PC, dec_en: 1'b0, dec_load: 1'b0,
              mul_en: 1'b0, div_start: 1'b0, commit: CM_NONE};
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          if (st_i.phase == PH_STOPPED) begin
            cmd_o.commit = CM_STOPPED;
          end else if (operation_i && st_i.pc_off) begin
            cmd_o.commit = CM_OFF_END;
          end
        end
      end
      S_LOAD_DEC: begin
        cmd_o.dec_en   = 1'b1;
        cmd_o.dec_load = 1'b1;
      end
      S_LOAD: cmd_o.commit = CM_LOAD;
      S_FETCH: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PC;
      end
      S_DECODE: cmd_o.dec_en = 1'b1;
      S_OPERAND: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_OPD;
      end
      S_EXEC: begin
        if (st_i.is_mul) begin
          cmd_o.mul_en = 1'b1;
        end else if (st_i.is_div) begin
          cmd_o.div_start = 1'b1;
        end else begin
          cmd_o.commit = CM_EXEC;
        end
      end
      S_MULT:   cmd_o.commit = CM_EXEC;
      S_DIVIDE: if (st_i.div_done) cmd_o.commit = CM_EXEC;
      default: ;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

endmodule

FILE: hw/rtl/accumulator_machine_core.sv
// Top level of the accumulator machine core: controller plus datapath.
// Accept to strobe, a load runs LOAD_DEC, LOAD; an instruction FETCH, DECODE, OPERAND,
// EXEC, then MULT or DIVIDE (14-step divider); a stopped or end-of-memory item commits
// on accept. One item at a time; the next transfer is taken in the strobe cycle.
// Reset is asynchronous: state clears at once and per-word written flags make the
// whole word memory read as zero, with no clearing pass. The receiver cannot stall.
module accumulator_machine_core import acm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     operation_i,
  input  logic [PC_W-1:0]          address_i,
  input  logic signed [WORD_W-1:0] word_i,
  input  logic signed [WORD_W-1:0] read_value_i,
  output logic                     done_o,
  output logic [3:0]               status_o,
  output logic                     write_valid_o,
  output logic [OPD_W-1:0]         write_address_o,
  output logic signed [WORD_W-1:0] write_value_o,
  output logic signed [WORD_W-1:0] accumulator_now_o,
  output logic [PC_W-1:0]          counter_now_o
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  acm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .st_i        (st),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  acm_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .address_i         (address_i),
    .word_i            (word_i),
    .read_value_i      (read_value_i),
    .st_o              (st),
    .done_o            (done_o),
    .status_o          (status_o),
    .write_valid_o     (write_valid_o),
    .write_address_o   (write_address_o),
    .write_value_o     (write_value_o),
    .accumulator_now_o (accumulator_now_o),
    .counter_now_o     (counter_now_o)
  );

endmodule

FILE: hw/rtl/acm_checker.sv
// Port-level checks of the accumulator machine core, bound to the top level.
module acm_checker import acm_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            done_o,
  input logic [3:0]      status_o,
  input logic            write_valid_o,
  input logic [PC_W-1:0] counter_now_o
);

  // A result strobe only while the core is free
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // Every accepted transfer shows work or a result in the next cycle
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("accepted item dropped");

  // Finishing an item always produces a result
  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("item finished without result");

  // A printed value only comes with a good or end-of-memory status
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_valid_o) |-> (status_o == ST_OK || status_o == ST_OFF_END))
    else $error("write reported with error status");

  // Counter never goes beyond one past the end of memory
  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (counter_now_o <= PC_W'(MEM_WORDS))) else $error("counter out of range");

endmodule

bind accumulator_machine_core acm_checker u_acm_checker (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the accumulator machine core: directed loads, random program, run.
module testbench;
  import acm_pkg::*;

  // One input item as presented on the command ports
  typedef struct packed {
    logic                     op;
    logic [PC_W-1:0]          addr;
    logic signed [WORD_W-1:0] word;
    logic signed [WORD_W-1:0] rv;
  } machine_item_t;

  // One result as seen on the result ports
  typedef struct packed {
    logic [3:0]               status;
    logic                     wr_valid;
    logic [OPD_W-1:0]         wr_addr;
    logic signed [WORD_W-1:0] wr_value;
    logic signed [WORD_W-1:0] acc;
    logic [PC_W-1:0]          counter;
  } machine_result_t;

  // Directed row: item plus an optional hand-written status
  typedef struct packed {
    machine_item_t item;
    logic          typed;
    logic [3:0]    status;
  } dir_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     operation_i;
  logic [PC_W-1:0]          address_i;
  logic signed [WORD_W-1:0] word_i;
  logic signed [WORD_W-1:0] read_value_i;
  logic                     done_o;
  logic [3:0]               status_o;
  logic                     write_valid_o;
  logic [OPD_W-1:0]         write_address_o;
  logic signed [WORD_W-1:0] write_value_o;
  logic signed [WORD_W-1:0] accumulator_now_o;
  logic [PC_W-1:0]          counter_now_o;

  accumulator_machine_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .word_i            (word_i),
    .read_value_i      (read_value_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .write_valid_o     (write_valid_o),
    .write_address_o   (write_address_o),
    .write_value_o     (write_value_o),
    .accumulator_now_o (accumulator_now_o),
    .counter_now_o     (counter_now_o)
  );

  localparam bit OP_LOAD_WORD = 1'b0;
  localparam bit OP_EXECUTE   = 1'b1;
  localparam int ITEMS_TOTAL  = 600;
  localparam int CODE_TOP     = 69;  // code lives in 0..CODE_TOP, data above it

  // Machine state mirrored by the predictor
  logic signed [WORD_W-1:0] mirror_mem [MEM_WORDS];
  int                       mirror_acc;
  int                       mirror_pc;
  phase_e                   mirror_phase;

  machine_result_t pending_results [$];
  int              mismatches;
  int              items_sent;
  int              burst_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Directed part: load validation extremes, then one load of each opcode from READ to BRZERO
  localparam int DIR_ROWS = 24;
  dir_row_t dir_tab [DIR_ROWS] = '{
    // op, address, word, read value, typed, status
    '{'{OP_LOAD_WORD, 7'd0,   15'd0,                  15'd0},    1'b1, ST_OK},
    '{'{OP_LOAD_WORD, 7'd99,  15'(OPC_HALT * 100 + 99), 15'h3fff}, 1'b1, ST_OK},
    '{'{OP_LOAD_WORD, 7'd99,  15'd9999,               15'h4000}, 1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd0,   15'h7fff,               15'd0},    1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd0,   15'h4000,               15'h7fff}, 1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd0,   15'h3fff,               15'd0},    1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd100, 15'd0,                  15'd0},    1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd127, 15'(OPC_READ * 100),    15'h2aaa}, 1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd5,   15'd1234,               15'h5555}, 1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd5,   15'd4400,               15'd0},    1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd5,   15'd100,                15'd0},    1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd64,  15'h2aaa,               15'd0},    1'b1, ST_LOAD_REJ},
    '{'{OP_LOAD_WORD, 7'd5,   15'd99,                 15'd0},    1'b1, ST_OK},
    '{'{OP_LOAD_WORD, 7'd10,  15'(OPC_READ * 100 + 70),   15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd11,  15'(OPC_WRITE * 100 + 71),  15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd12,  15'(OPC_LOAD * 100 + 72),   15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd13,  15'(OPC_STORE * 100 + 73),  15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd14,  15'(OPC_ADD * 100 + 74),    15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd15,  15'(OPC_SUB * 100 + 75),    15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd16,  15'(OPC_DIV * 100 + 76),    15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd17,  15'(OPC_MUL * 100 + 77),    15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd18,  15'(OPC_BR * 100),          15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd19,  15'(OPC_BRNEG * 100 + 1),   15'd0}, 1'b0, ST_OK},
    '{'{OP_LOAD_WORD, 7'd20,  15'(OPC_BRZERO * 100 + 2),  15'd0}, 1'b0, ST_OK}
  };

  // Opcode table of the machine
  function automatic bit opcode_valid(input int opc);
    case (opc)
      OPC_NOP, OPC_READ, OPC_WRITE, OPC_LOAD, OPC_STORE, OPC_ADD, OPC_SUB,
      OPC_DIV, OPC_MUL, OPC_BR, OPC_BRNEG, OPC_BRZERO, OPC_HALT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Predictor: applies one item to the mirrored machine, returns its result
  function automatic machine_result_t simulate_machine_item(input machine_item_t it);
    machine_result_t r;
    int  w, rv, iw, opc, opd, nxt, sum;
    bit  stop;
    r        = '0;
    r.status = ST_OK;
    w        = it.word;
    rv       = it.rv;
    stop     = 1'b0;
    if (mirror_phase == PH_STOPPED) begin
      r.status = ST_STOPPED;
    end else if (it.op == OP_LOAD_WORD) begin
      if (mirror_phase != PH_LOADING || it.addr >= MEM_WORDS || w < 0 ||
          w > int'(WORD_MAX) || (w % 100) >= MEM_WORDS || !opcode_valid(w / 100)) begin
        r.status = ST_LOAD_REJ;
      end else begin
        mirror_mem[it.addr] = WORD_W'(w);
      end
    end else begin
      mirror_phase = PH_RUNNING;
      if (mirror_pc >= MEM_WORDS) begin
        r.status     = ST_OFF_END;
        mirror_phase = PH_STOPPED;
      end else begin
        iw  = mirror_mem[mirror_pc];
        opc = iw / 100;
        opd = iw % 100;
        nxt = mirror_pc + 1;
        if (!opcode_valid(opc)) begin
          r.status = ST_BAD_OPC;
          stop     = 1'b1;
        end else if (opc != int'(OPC_NOP) && (opd < 0 || opd >= MEM_WORDS)) begin
          r.status = ST_BAD_ADDR;
          stop     = 1'b1;
        end else begin
          case (opc)
            OPC_READ: begin
              // saturate the supplied number
              if (rv > int'(WORD_MAX)) rv = int'(WORD_MAX);
              if (rv < -int'(WORD_MAX)) rv = -int'(WORD_MAX);
              mirror_mem[opd] = WORD_W'(rv);
            end
            OPC_WRITE: begin
              r.wr_valid = 1'b1;
              r.wr_addr  = OPD_W'(opd);
              r.wr_value = mirror_mem[opd];
            end
            OPC_LOAD:  mirror_acc = mirror_mem[opd];
            OPC_STORE: mirror_mem[opd] = WORD_W'(mirror_acc);
            OPC_ADD, OPC_SUB, OPC_MUL: begin
              if (opc == OPC_ADD)      sum = mirror_acc + int'(mirror_mem[opd]);
              else if (opc == OPC_SUB) sum = mirror_acc - int'(mirror_mem[opd]);
              else                     sum = mirror_acc * int'(mirror_mem[opd]);
              if (sum > int'(WORD_MAX) || sum < -int'(WORD_MAX)) begin
                r.status   = ST_OVERFLOW;
                mirror_acc = 0;
                stop       = 1'b1;
              end else begin
                mirror_acc = sum;
              end
            end
            OPC_DIV: begin
              if (mirror_mem[opd] == 0) begin
                r.status   = ST_DIV_ZERO;
                mirror_acc = 0;
                stop       = 1'b1;
              end else begin
                mirror_acc = mirror_acc / int'(mirror_mem[opd]);
              end
            end
            OPC_BR:     nxt = opd;
            OPC_BRNEG:  if (mirror_acc < 0) nxt = opd;
            OPC_BRZERO: if (mirror_acc == 0) nxt = opd;
            OPC_HALT: begin
              r.status = ST_HALTED;
              stop     = 1'b1;
            end
            default: ;
          endcase
        end
        if (stop) begin
          mirror_phase = PH_STOPPED;
        end else begin
          mirror_pc = nxt;
          if (mirror_pc >= MEM_WORDS) begin
            r.status     = ST_OFF_END;
            mirror_phase = PH_STOPPED;
          end
        end
      end
    end
    r.acc     = WORD_W'(mirror_acc);
    r.counter = PC_W'(mirror_pc);
    return r;
  endfunction

  // Random instruction for the code region
  function automatic int code_word();
    int pick, data_opd;
    pick     = $urandom_range(0, 99);
    // mostly data region, sometimes anywhere so code gets overwritten
    data_opd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(70, 99);
    if (pick < 10)      return OPC_READ * 100 + data_opd;
    else if (pick < 22) return OPC_WRITE * 100 + data_opd;
    else if (pick < 35) return OPC_LOAD * 100 + data_opd;
    else if (pick < 45) return OPC_STORE * 100 + data_opd;
    else if (pick < 57) return OPC_ADD * 100 + data_opd;
    else if (pick < 69) return OPC_SUB * 100 + data_opd;
    else if (pick < 72) return OPC_DIV * 100 + data_opd;
    else if (pick < 75) return OPC_MUL * 100 + data_opd;
    else if (pick < 81) return OPC_BR * 100 + $urandom_range(0, CODE_TOP);
    else if (pick < 87) return OPC_BRNEG * 100 + $urandom_range(0, CODE_TOP);
    else if (pick < 93) return OPC_BRZERO * 100 + $urandom_range(0, CODE_TOP);
    else if (pick < 99) return OPC_NOP * 100 + $urandom_range(0, 99);
    else                return OPC_HALT * 100 + $urandom_range(0, 99);
  endfunction

  // Item with address, word and read value random, mostly rejected or ignored
  function automatic machine_item_t noise_item(input bit op);
    machine_item_t it;
    it.op   = op;
    it.addr = PC_W'($urandom_range(0, 127));
    it.word = WORD_W'($urandom_range(0, 32767));
    it.rv   = WORD_W'($urandom_range(0, 32767));
    return it;
  endfunction

  // Present one item in bursts with random gaps; record its expected result on transfer
  task automatic send_item(input machine_item_t it, input bit typed, input logic [3:0] st);
    machine_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk_i);
      end
    end
    burst_left--;
    start        <= 1'b1;
    operation_i  <= it.op;
    address_i    <= it.addr;
    word_i       <= it.word;
    read_value_i <= it.rv;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = simulate_machine_item(it);
    if (typed) begin
      // loading phase: nothing but the status can be non-zero
      r        = '0;
      r.status = st;
    end
    pending_results.push_back(r);
    items_sent++;
  endtask

  // Compare one field, report the difference
  task automatic check_field(input string nm, input logic signed [15:0] want_v,
                             input logic signed [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d got %0d", $time, nm, want_v, got_v);
      mismatches++;
    end
  endtask

  // Result monitor: each strobe is matched with the oldest expectation
  always @(posedge clk_i) begin
    machine_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d", $time, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("write_valid", want.wr_valid, write_valid_o);
        check_field("write_address", want.wr_addr, write_address_o);
        check_field("write_value", want.wr_value, write_value_o);
        check_field("accumulator_now", want.acc, accumulator_now_o);
        check_field("counter_now", want.counter, counter_now_o);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    machine_item_t it;
    int            w;
    mismatches   = 0;
    items_sent   = 0;
    burst_left   = 0;
    for (int k = 0; k < MEM_WORDS; k++) mirror_mem[k] = '0;
    mirror_acc   = 0;
    mirror_pc    = 0;
    mirror_phase = PH_LOADING;
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = 1'b0;
    address_i    = '0;
    word_i       = '0;
    read_value_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int k = 0; k < DIR_ROWS; k++)
      send_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].status);

    // random program: code up to CODE_TOP, small numbers above, stray loads between
    for (int a = 0; a < MEM_WORDS; a++) begin
      if ($urandom_range(0, 7) == 0) send_item(noise_item(OP_LOAD_WORD), 1'b0, ST_OK);
      if (a < CODE_TOP)
        w = code_word();
      else if (a == CODE_TOP)
        w = ($urandom_range(0, 3) != 0) ? OPC_BR * 100 : code_word();
      else
        w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 99);
      it.op   = OP_LOAD_WORD;
      it.addr = PC_W'(a);
      it.word = WORD_W'(w);
      it.rv   = WORD_W'($urandom_range(0, 32767));
      send_item(it, 1'b0, ST_OK);
    end

    // run the program, with stray loads among the steps
    while (items_sent < ITEMS_TOTAL) begin
      if ($urandom_range(0, 9) == 0) begin
        it = noise_item(OP_LOAD_WORD);
      end else begin
        it    = noise_item(OP_EXECUTE);
        if ($urandom_range(0, 7) != 0) it.rv = WORD_W'($urandom_range(0, 400) - 200);
      end
      send_item(it, 1'b0, ST_OK);
      // one hold-off with the pipeline drained
      if (items_sent == 180) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
        repeat ($urandom_range(5, 30)) @(posedge clk_i);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
